### sv/lsepe_pkg.sv
// shared types and constants for the led strip effect pixel encoder
package lsepe_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int MAX_PIXELS = 256;
    localparam int BIT_CNT_W = $clog2(BITS_PER_PIXEL);

    // rainbow cycle position comes from an 8-bit quotient, two bits per stage
    localparam int QUO_W = 8;
    localparam int QUO_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / QUO_BITS_PER_STAGE;

    typedef enum logic [2:0] {
        MODE_RAINBOW  = 3'd0,
        MODE_CYCLE    = 3'd1,
        MODE_THEATER  = 3'd2,
        MODE_CHASE_RB = 3'd3,
        MODE_SOLID    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_COUNT = 3'd1,
        REG_COLOR = 3'd2,
        REG_ONE   = 3'd3,
        REG_ZERO  = 3'd4
    } reg_idx_t;

    localparam logic [2:0]  MODE_RST  = 3'd0;
    localparam logic [8:0]  COUNT_RST = 9'd60;
    localparam logic [23:0] COLOR_RST = 24'd0;
    localparam logic [7:0]  ONE_RST   = 8'd140;
    localparam logic [7:0]  ZERO_RST  = 8'd70;

    typedef struct packed {
        logic [2:0]  mode;
        logic [8:0]  pixel_count;
        logic [23:0] fixed_color;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  pixel_index;
        logic [10:0] effect_step;
        logic [1:0]  chase_phase;
        logic        chase_on;
    } pix_t;

endpackage

### sv/lsepe_color_pipe.sv
// stalling pipeline that turns one pixel request into its grb color word
module lsepe_color_pipe
    import lsepe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  pix_t        in_pix,
    output logic        in_ready,
    output logic        out_valid,
    output logic [23:0] out_color,
    input  logic        out_take
);

    // entry, divider stages, then three wheel stages
    localparam int ST_A = DIV_STAGES + 1;
    localparam int ST_B = DIV_STAGES + 2;
    localparam int ST_C = DIV_STAGES + 3;
    localparam int NSTAGES = DIV_STAGES + 4;

    typedef enum logic [1:0] {
        SEG_RB = 2'd0,
        SEG_GB = 2'd1,
        SEG_RG = 2'd2
    } seg_t;

    typedef struct packed {
        logic [8:0]       rem;
        logic [QUO_W-1:0] quo;
        logic [7:0]       wpos;
        logic [7:0]       step_lo;
        logic             lit;
    } div_t;

    typedef struct packed {
        seg_t       seg;
        logic [7:0] lin;
        logic [7:0] inv;
        logic       lit;
    } whl_t;

    typedef struct packed {
        seg_t       seg;
        logic [4:0] lin_q;
        logic [4:0] inv_q;
        logic       lit;
    } frac_t;

    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s4;
        logic [2:0] t3;
        logic [2:0] t2;
        begin
            s4 = {2'b0, v[1:0]} + {2'b0, v[3:2]} + {2'b0, v[5:4]} + {2'b0, v[7:6]};
            t3 = {1'b0, s4[3:2]} + {1'b0, s4[1:0]};
            t2 = {2'b0, t3[2]} + {1'b0, t3[1:0]};
            return (t2 >= 3'd3) ? 2'(t2 - 3'd3) : t2[1:0];
        end
    endfunction

    function automatic div_t div_step(input div_t x, input logic [8:0] d);
        logic [9:0] r2;
        div_t       y;
        begin
            y = x;
            for (int b = 0; b < QUO_BITS_PER_STAGE; b++)
            begin
                r2 = {y.rem, 1'b0};
                if (r2 >= {1'b0, d})
                begin
                    y.rem = 9'(r2 - {1'b0, d});
                    y.quo = {y.quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    y.rem = r2[8:0];
                    y.quo = {y.quo[QUO_W-2:0], 1'b0};
                end
            end
            return y;
        end
    endfunction

    // x / 10 for x below 256 by reciprocal multiply
    function automatic logic [4:0] div10(input logic [7:0] x);
        logic [15:0] prod;
        begin
            prod = {8'b0, x} * 16'd205;
            return prod[15:11];
        end
    endfunction

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] adv;

    div_t        div_reg [0:DIV_STAGES];
    div_t        div_next;
    whl_t        whl_reg;
    whl_t        whl_next;
    frac_t       frac_reg;
    frac_t       frac_next;
    logic [23:0] color_reg;
    logic [23:0] color_next;

    logic        in_range;
    logic [11:0] chase_sum;
    logic [8:0]  chase_fold;
    logic [7:0]  chase_pos;
    logic [7:0]  w;
    logic [7:0]  p;
    logic [7:0]  x;
    logic [9:0]  tri3;
    logic [23:0] wheel;

    // stage advances when empty or when the one after it moves
    always_comb
    begin
        adv[NSTAGES-1] = !valid_reg[NSTAGES-1] || out_take;
        for (int k = NSTAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NSTAGES-1];
    assign out_color = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid && in_range;
            end
            for (int k = 1; k < NSTAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // entry: range check, chase match and the positions that need no divide
    always_comb
    begin
        in_range = ({1'b0, in_pix.pixel_index} < cfg.pixel_count)
                && (int'(in_pix.pixel_index) < MAX_PIXELS);
        chase_sum = {4'b0, in_pix.pixel_index} - {10'b0, in_pix.chase_phase}
                  + {1'b0, in_pix.effect_step};
        chase_fold = {1'b0, chase_sum[7:0]} + {6'b0, chase_sum[10:8]};
        chase_pos = (chase_fold >= 9'd255) ? 8'(chase_fold - 9'd255) : chase_fold[7:0];
        div_next.rem = {1'b0, in_pix.pixel_index};
        div_next.quo = '0;
        div_next.step_lo = in_pix.effect_step[7:0];
        div_next.lit = in_pix.chase_on
                    && (mod3(in_pix.pixel_index) == in_pix.chase_phase);
        if (mode_t'(cfg.mode) == MODE_CHASE_RB)
        begin
            div_next.wpos = chase_pos;
        end
        else
        begin
            div_next.wpos = in_pix.pixel_index + in_pix.effect_step[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            div_reg[0] <= div_next;
        end
        for (int d = 1; d <= DIV_STAGES; d++)
        begin
            if (adv[d])
            begin
                div_reg[d] <= div_step(div_reg[d-1], cfg.pixel_count);
            end
        end
    end

    // wheel stage a: segment and 3x offset
    always_comb
    begin
        if (mode_t'(cfg.mode) == MODE_CYCLE)
        begin
            w = div_reg[DIV_STAGES].quo + div_reg[DIV_STAGES].step_lo;
        end
        else
        begin
            w = div_reg[DIV_STAGES].wpos;
        end
        p = ~w;
        if (p < 8'd85)
        begin
            whl_next.seg = SEG_RB;
            x = p;
        end
        else if (p < 8'd170)
        begin
            whl_next.seg = SEG_GB;
            x = p - 8'd85;
        end
        else
        begin
            whl_next.seg = SEG_RG;
            x = p - 8'd170;
        end
        tri3 = {2'b0, x} + {1'b0, x, 1'b0};
        whl_next.lin = tri3[7:0];
        whl_next.inv = 8'd255 - tri3[7:0];
        whl_next.lit = div_reg[DIV_STAGES].lit;
    end

    // wheel stage b: divide both terms by ten
    always_comb
    begin
        frac_next.seg   = whl_reg.seg;
        frac_next.lin_q = div10(whl_reg.lin);
        frac_next.inv_q = div10(whl_reg.inv);
        frac_next.lit   = whl_reg.lit;
    end

    // wheel stage c: grb word and effect select
    always_comb
    begin
        case (frac_reg.seg)
            SEG_RB:  wheel = {8'd0, 3'd0, frac_reg.inv_q, 3'd0, frac_reg.lin_q};
            SEG_GB:  wheel = {3'd0, frac_reg.lin_q, 8'd0, 3'd0, frac_reg.inv_q};
            default: wheel = {3'd0, frac_reg.inv_q, 3'd0, frac_reg.lin_q, 8'd0};
        endcase
        case (mode_t'(cfg.mode))
            MODE_RAINBOW:  color_next = wheel;
            MODE_CYCLE:    color_next = wheel;
            MODE_THEATER:  color_next = frac_reg.lit ? cfg.fixed_color : 24'd0;
            MODE_CHASE_RB: color_next = frac_reg.lit ? wheel : 24'd0;
            MODE_SOLID:    color_next = cfg.fixed_color;
            default:       color_next = 24'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_A])
        begin
            whl_reg <= whl_next;
        end
        if (adv[ST_B])
        begin
            frac_reg <= frac_next;
        end
        if (adv[ST_C])
        begin
            color_reg <= color_next;
        end
    end

endmodule

### sv/led_strip_effect_pixel_encoder_top.sv
// top level of the led strip effect pixel encoder: config port, color pipe, bit serializer
//
// one start per pixel: pixel_index, effect_step, chase_phase and chase_on are taken at
// the rising edge where start is high and busy is low. a pixel inside the strip
// (pixel_index below pixel_count) turns into 24 words on duty_code, one per cycle,
// green msb first, then red, then blue; each word is one_code for a set color bit and
// zero_code for a clear one, and last_bit marks the 24th. result_valid marks each word
// for exactly one cycle and there is no way to hold the words off, so the receiver must
// take every one. a pixel beyond the strip is taken and gives no words at all.
// the 24 words of a pixel always come back to back, and pixels follow each other with no
// gap while the next color is ready, as the serializer sends one bit a cycle and reloads
// on its last bit without a pause. the color is worked out in an 8-stage
// pipeline (entry, four 2-bit divider stages for rainbow cycle, three color wheel
// stages) that keeps taking pixels while the serializer is sending, so busy stays low
// until the pipeline fills; with the serializer free, a pixel's color passes through the
// entry, divider and wheel stages into the serializer, whose register gives the first word.
// registers sit on the apb port at byte addresses 0 effect_mode, 4 pixel_count, 8 fixed_color,
// 12 one_code, 16 zero_code; write them only while no pixel is in flight.
module led_strip_effect_pixel_encoder_top
    import lsepe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel request
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  pixel_index,
    input  logic [10:0] effect_step,
    input  logic [1:0]  chase_phase,
    input  logic        chase_on,
    // word stream
    output logic        result_valid,
    output logic [7:0]  duty_code,
    output logic        last_bit
);

    logic [2:0]  mode_reg;
    logic [8:0]  count_reg;
    logic [23:0] color_reg;
    logic [7:0]  one_reg;
    logic [7:0]  zero_reg;

    logic        cfg_wr;
    cfg_t        cfg;
    pix_t        pix;

    logic        pipe_ready;
    logic        pipe_valid;
    logic [23:0] pipe_color;
    logic        pipe_take;

    logic                      ser_active_reg;
    logic                      ser_active_next;
    logic [BIT_CNT_W-1:0]      ser_cnt_reg;
    logic [BIT_CNT_W-1:0]      ser_cnt_next;
    logic [BITS_PER_PIXEL-1:0] ser_shift_reg;
    logic [BITS_PER_PIXEL-1:0] ser_shift_next;
    logic                      ser_last;

    // config registers, written in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RST;
            count_reg <= COUNT_RST;
            color_reg <= COLOR_RST;
            one_reg   <= ONE_RST;
            zero_reg  <= ZERO_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_MODE:  mode_reg  <= pwdata[2:0];
                REG_COUNT: count_reg <= pwdata[8:0];
                REG_COLOR: color_reg <= pwdata[23:0];
                REG_ONE:   one_reg   <= pwdata[7:0];
                REG_ZERO:  zero_reg  <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_MODE:  prdata = {29'd0, mode_reg};
            REG_COUNT: prdata = {23'd0, count_reg};
            REG_COLOR: prdata = {8'd0, color_reg};
            REG_ONE:   prdata = {24'd0, one_reg};
            REG_ZERO:  prdata = {24'd0, zero_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // color pipeline
    assign cfg.mode        = mode_reg;
    assign cfg.pixel_count = count_reg;
    assign cfg.fixed_color = color_reg;

    assign pix.pixel_index = pixel_index;
    assign pix.effect_step = effect_step;
    assign pix.chase_phase = chase_phase;
    assign pix.chase_on    = chase_on;

    assign busy = !pipe_ready;

    lsepe_color_pipe u_color_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (start),
        .in_pix    (pix),
        .in_ready  (pipe_ready),
        .out_valid (pipe_valid),
        .out_color (pipe_color),
        .out_take  (pipe_take)
    );

    // serializer: reloads on the last bit so pixels run back to back
    assign ser_last  = ser_cnt_reg == BIT_CNT_W'(BITS_PER_PIXEL - 1);
    assign pipe_take = pipe_valid && (!ser_active_reg || ser_last);

    always_comb
    begin
        ser_active_next = ser_active_reg;
        ser_cnt_next    = ser_cnt_reg;
        ser_shift_next  = ser_shift_reg;
        if (pipe_take)
        begin
            ser_active_next = 1'b1;
            ser_cnt_next    = '0;
            ser_shift_next  = pipe_color;
        end
        else if (ser_active_reg)
        begin
            ser_shift_next = {ser_shift_reg[BITS_PER_PIXEL-2:0], 1'b0};
            if (ser_last)
            begin
                ser_active_next = 1'b0;
                ser_cnt_next    = '0;
            end
            else
            begin
                ser_cnt_next = ser_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_active_reg <= 1'b0;
            ser_cnt_reg    <= '0;
        end
        else
        begin
            ser_active_reg <= ser_active_next;
            ser_cnt_reg    <= ser_cnt_next;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        ser_shift_reg <= ser_shift_next;
    end

    assign result_valid = ser_active_reg;
    assign duty_code    = ser_shift_reg[BITS_PER_PIXEL-1] ? one_reg : zero_reg;
    assign last_bit     = ser_active_reg && ser_last;

    // a pixel's words never break up before its last one
    a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_bit |=> result_valid)
        else $error("word stream broke before last bit");

    // two last words can never be adjacent
    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        last_bit |=> !last_bit)
        else $error("last bit on adjacent words");

    // the bit counter only runs while a pixel is being sent
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ser_cnt_reg != '0 |-> ser_active_reg)
        else $error("bit counter moved while serializer idle");

endmodule
